// ----- design/etcl_pkg.sv -----
// Shared types and constants for the ESC throttle and current limiter.
// Used by the register bank, the serial divider and the top level; no dependencies.
package etcl_pkg;

   // Pulse width limits in timer counts
   localparam logic [11:0] PULSE_INVALID_ABOVE = 12'd300;
   localparam logic [11:0] PULSE_CLIP          = 12'd200;
   localparam logic [7:0]  PULSE_SPAN_TOP      = 8'd190;

   // Widths of the shared divider
   localparam int DIV_WIDTH     = 16;
   localparam int DIVISOR_WIDTH = 8;
   localparam int COUNT_WIDTH   = $clog2(DIV_WIDTH);

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_PULSE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_DUTY      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FULL_DUTY     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRIP_CURRENT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AVERAGE_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MANUAL_DUTY   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOUBLE_WIDE   = 3'd6;

   // Register reset values
   localparam logic [7:0] RST_MIN_PULSE     = 8'd10;
   localparam logic [7:0] RST_MIN_DUTY      = 8'd1;
   localparam logic [7:0] RST_FULL_DUTY     = 8'd255;
   localparam logic [9:0] RST_TRIP_CURRENT  = 10'd200;
   localparam logic [7:0] RST_AVERAGE_LIMIT = 8'd65;
   localparam logic [7:0] RST_MANUAL_DUTY   = 8'd0;
   localparam logic       RST_DOUBLE_WIDE   = 1'b0;

   // Current register contents as seen by the datapath
   typedef struct packed {
      logic [7:0] min_pulse;
      logic [7:0] min_duty;
      logic [7:0] full_duty;
      logic [9:0] trip_current;
      logic [7:0] average_limit;
      logic [7:0] manual_duty;
      logic       double_wide;
   } cfg_type;

   // Divider result back to the sequencer
   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } div_status_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage

// ----- design/etcl_csr.sv -----
// Configuration register bank of the throttle and current limiter.
// Depends on etcl_pkg for register indexes, reset values and the cfg_type struct.
module etcl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [etcl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [etcl_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output etcl_pkg::cfg_type                   cfg
);

   etcl_pkg::cfg_type cfg_ff;
   etcl_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            etcl_pkg::REG_MIN_PULSE:     cfg_in.min_pulse     = csr_data[7:0];
            etcl_pkg::REG_MIN_DUTY:      cfg_in.min_duty      = csr_data[7:0];
            etcl_pkg::REG_FULL_DUTY:     cfg_in.full_duty     = csr_data[7:0];
            etcl_pkg::REG_TRIP_CURRENT:  cfg_in.trip_current  = csr_data[9:0];
            etcl_pkg::REG_AVERAGE_LIMIT: cfg_in.average_limit = csr_data[7:0];
            etcl_pkg::REG_MANUAL_DUTY:   cfg_in.manual_duty   = csr_data[7:0];
            etcl_pkg::REG_DOUBLE_WIDE:   cfg_in.double_wide   = csr_data[0];
            default: ;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse     <= etcl_pkg::RST_MIN_PULSE;
         cfg_ff.min_duty      <= etcl_pkg::RST_MIN_DUTY;
         cfg_ff.full_duty     <= etcl_pkg::RST_FULL_DUTY;
         cfg_ff.trip_current  <= etcl_pkg::RST_TRIP_CURRENT;
         cfg_ff.average_limit <= etcl_pkg::RST_AVERAGE_LIMIT;
         cfg_ff.manual_duty   <= etcl_pkg::RST_MANUAL_DUTY;
         cfg_ff.double_wide   <= etcl_pkg::RST_DOUBLE_WIDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/etcl_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, for the pulse scaling.
// Depends on etcl_pkg for widths and the div_status_type struct.
module etcl_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [etcl_pkg::DIV_WIDTH-1:0]         dividend,
   input  logic [etcl_pkg::DIVISOR_WIDTH-1:0]     divisor,
   output etcl_pkg::div_status_type               status
);

   logic                                 busy_ff,    busy_in;
   logic                                 done_ff,    done_in;
   logic [etcl_pkg::COUNT_WIDTH-1:0]     count_ff,   count_in;
   logic [etcl_pkg::DIVISOR_WIDTH-1:0]   rem_ff,     rem_in;
   logic [etcl_pkg::DIVISOR_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [etcl_pkg::DIV_WIDTH-1:0]       quo_ff,     quo_in;
   logic [etcl_pkg::DIVISOR_WIDTH:0]     rem_shift;
   logic                                 fits;

   // One restoring step: shift the next dividend bit into the remainder and
   // subtract the divisor where it fits.
   assign rem_shift = {rem_ff, quo_ff[etcl_pkg::DIV_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? etcl_pkg::DIVISOR_WIDTH'(rem_shift - {1'b0, divisor_ff})
                         : rem_shift[etcl_pkg::DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[etcl_pkg::DIV_WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == etcl_pkg::COUNT_WIDTH'(etcl_pkg::DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ----- design/esc_throttle_current_limiter_top.sv -----
// A pass captures the transaction, registers the scaling product in ST_MUL, starts the
// 16-step serial divider used for pulse scaling in ST_LOAD, waits for it in ST_WAIT, and
// loads the result register in ST_FIN, waiting there while a held result sees rsp_stall.
// One transaction is in work at a time; req_stall is high until the pass completes.
// Reset (synchronous): registers to their reset values, setpoint and mean current to zero,
// duty ceiling to 255, warning LED on, no result pending.
module esc_throttle_current_limiter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_bus_valid,
   input  logic [7:0]                           req_bus_throttle,
   input  logic                                 req_serial_valid,
   input  logic                                 req_pulse_valid,
   input  logic [11:0]                          req_pulse_width,
   input  logic [9:0]                           req_current_sample,
   input  logic                                 req_average_due,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_duty,
   output logic [8:0]                           rsp_compare_a,
   output logic [7:0]                           rsp_compare_b,
   output logic                                 rsp_overcurrent,
   output logic                                 rsp_warning_led,
   output logic [7:0]                           rsp_mean_current,
   output logic [7:0]                           rsp_ceiling,
   input  logic                                 csr_write_enable,
   input  logic [etcl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [etcl_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   etcl_pkg::cfg_type        cfg;
   etcl_pkg::div_status_type div_status;
   etcl_pkg::state_type      state_ff, state_in;

   // Captured transaction
   logic       bus_valid_ff, serial_valid_ff, pulse_valid_ff, average_due_ff;
   logic [7:0] bus_throttle_ff;
   logic [11:0] pulse_width_ff;
   logic [9:0] current_ff;

   // Scaling operands prepared before the division
   logic [7:0]  w_eff;
   logic [8:0]  duty_span;
   logic [7:0]  duty_mag;
   logic [7:0]  pulse_diff;
   logic [15:0] product_ff, product_in;
   logic        neg_ff, neg_in;
   logic        below_ff, below_in;
   logic        steep_ff, steep_in;
   logic [7:0]  span_ff, span_in;

   // Controller state
   logic [7:0] setpoint_ff, setpoint_in;
   logic [7:0] mean_ff, mean_in;
   logic [7:0] ceiling_ff, ceiling_in;
   logic       led_ff, led_in;

   // Final pass values
   logic [17:0] scaled_val;
   logic [7:0]  pulse_setpoint;
   logic [7:0]  duty;
   logic [8:0]  compare_a;
   logic        over;
   logic [9:0]  current_eff;
   logic        accept;
   logic        finish;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_duty_ff;
   logic [8:0] rsp_compare_a_ff;
   logic       rsp_over_ff;
   logic       rsp_led_ff;
   logic [7:0] rsp_mean_ff;
   logic [7:0] rsp_ceiling_ff;

   etcl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   etcl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == etcl_pkg::ST_LOAD),
      .dividend (product_ff),
      .divisor  (span_ff),
      .status   (div_status)
   );

   assign req_stall = state_ff != etcl_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == etcl_pkg::ST_FIN) && !(rsp_valid_ff && rsp_stall);

   // Sequencer: capture, multiply, divide, then settle the pass.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         etcl_pkg::ST_IDLE: if (accept) state_in = etcl_pkg::ST_MUL;
         etcl_pkg::ST_MUL:  state_in = etcl_pkg::ST_LOAD;
         etcl_pkg::ST_LOAD: state_in = etcl_pkg::ST_WAIT;
         etcl_pkg::ST_WAIT: if (div_status.done) state_in = etcl_pkg::ST_FIN;
         etcl_pkg::ST_FIN:  if (finish) state_in = etcl_pkg::ST_IDLE;
         default:           state_in = etcl_pkg::ST_IDLE;
      endcase
   end

   // Capture the transaction when it is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         bus_valid_ff    <= req_bus_valid;
         bus_throttle_ff <= req_bus_throttle;
         serial_valid_ff <= req_serial_valid;
         pulse_valid_ff  <= req_pulse_valid;
         pulse_width_ff  <= req_pulse_width;
         current_ff      <= req_current_sample;
         average_due_ff  <= req_average_due;
      end
   end

   // Pulse clipping and the magnitude of the scaling product.
   always_comb begin
      if (pulse_width_ff > etcl_pkg::PULSE_INVALID_ABOVE) begin
         w_eff = 8'd0;
      end else if (pulse_width_ff > etcl_pkg::PULSE_CLIP) begin
         w_eff = etcl_pkg::PULSE_CLIP[7:0];
      end else begin
         w_eff = pulse_width_ff[7:0];
      end
      duty_span  = {1'b0, cfg.full_duty} - {1'b0, cfg.min_duty};
      duty_mag   = duty_span[8] ? 8'(-duty_span) : duty_span[7:0];
      pulse_diff = w_eff - cfg.min_pulse;
      neg_in     = duty_span[8];
      below_in   = w_eff <= cfg.min_pulse;
      steep_in   = cfg.min_pulse >= etcl_pkg::PULSE_SPAN_TOP;
      span_in    = etcl_pkg::PULSE_SPAN_TOP - cfg.min_pulse;
      product_in = {8'd0, duty_mag} * {8'd0, pulse_diff};
   end

   always_ff @(posedge clock) begin
      if (state_ff == etcl_pkg::ST_MUL) begin
         product_ff <= product_in;
         neg_ff     <= neg_in;
         below_ff   <= below_in;
         steep_ff   <= steep_in;
         span_ff    <= span_in;
      end
   end

   // Apply the signed quotient, map widths at or below the minimum to zero and out-of-range values to full duty.
   always_comb begin
      scaled_val = {10'd0, cfg.min_duty}
                 + (neg_ff ? 18'(-{2'b00, div_status.quotient}) : {2'b00, div_status.quotient});
      if (below_ff) begin
         pulse_setpoint = 8'd0;
      end else if (steep_ff) begin
         pulse_setpoint = cfg.full_duty;
      end else if (scaled_val[17] || (scaled_val[16:0] > {9'd0, cfg.full_duty})) begin
         pulse_setpoint = cfg.full_duty;
      end else begin
         pulse_setpoint = scaled_val[7:0];
      end
   end

   // Setpoint source selection, ceiling clamp, overcurrent trip and averaging.
   always_comb begin
      setpoint_in = setpoint_ff;
      led_in      = led_ff;
      mean_in     = mean_ff;
      ceiling_in  = ceiling_ff;
      if (bus_valid_ff) begin
         setpoint_in = bus_throttle_ff;
         led_in      = 1'b0;
      end else if (serial_valid_ff) begin
         setpoint_in = setpoint_ff;
      end else if (pulse_valid_ff) begin
         setpoint_in = pulse_setpoint;
         led_in      = 1'b0;
      end else begin
         if (setpoint_ff != 8'd0) setpoint_in = setpoint_ff - 1'b1;
         led_in = 1'b1;
      end
      if (setpoint_in > cfg.full_duty) setpoint_in = cfg.full_duty;

      duty = (cfg.manual_duty != 8'd0) ? cfg.manual_duty : setpoint_in;
      if (duty > ceiling_ff) begin
         duty   = ceiling_ff;
         led_in = 1'b1;
      end

      over        = current_ff > cfg.trip_current;
      current_eff = current_ff;
      if (over) begin
         duty        = 8'd0;
         led_in      = 1'b1;
         current_eff = current_ff - 1'b1;
      end
      compare_a = cfg.double_wide ? {duty, 1'b0} : {1'b0, duty};

      if (average_due_ff) begin
         if ({2'b00, mean_ff} < current_eff) begin
            if (mean_ff != 8'hFF) mean_in = mean_ff + 1'b1;
         end else if ({2'b00, mean_ff} > current_eff) begin
            mean_in = mean_ff - 1'b1;
         end
         if (mean_in > cfg.average_limit) begin
            if (ceiling_ff != 8'd0) ceiling_in = ceiling_ff - 1'b1;
            led_in = 1'b1;
         end else if (ceiling_ff < cfg.full_duty) begin
            ceiling_in = ceiling_ff + 1'b1;
         end
      end
   end

   // Output register handshake: filled at the end of a pass, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

   // Control and controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etcl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         setpoint_ff  <= 8'd0;
         mean_ff      <= 8'd0;
         ceiling_ff   <= etcl_pkg::RST_FULL_DUTY;
         led_ff       <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            setpoint_ff <= setpoint_in;
            mean_ff     <= mean_in;
            ceiling_ff  <= ceiling_in;
            led_ff      <= led_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_duty_ff      <= duty;
         rsp_compare_a_ff <= compare_a;
         rsp_over_ff      <= over;
         rsp_led_ff       <= led_in;
         rsp_mean_ff      <= mean_in;
         rsp_ceiling_ff   <= ceiling_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_compare_a    = rsp_compare_a_ff;
   assign rsp_compare_b    = rsp_duty_ff;
   assign rsp_overcurrent  = rsp_over_ff;
   assign rsp_warning_led  = rsp_led_ff;
   assign rsp_mean_current = rsp_mean_ff;
   assign rsp_ceiling      = rsp_ceiling_ff;

`ifndef SYNTHESIS
   // An accepted transaction keeps the input side stalled in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input not stalled after accepting a transaction");

   // An overcurrent result carries zero duty and zero compare values and the LED on.
   a_trip_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overcurrent) |->
         (rsp_duty == 8'd0 && rsp_compare_a == 9'd0 && rsp_warning_led))
      else $error("overcurrent result with nonzero outputs");

   // The first compare value is the duty or twice the duty.
   a_compare_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_a == {1'b0, rsp_duty} || rsp_compare_a == {rsp_duty, 1'b0}))
      else $error("compare_a does not follow duty");

   // A result appears only at the end of a pass.
   a_result_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == etcl_pkg::ST_FIN))
      else $error("result raised outside the final step");
`endif

endmodule

// ----- verif/etcl_pass_checker.sv -----
// Checker for the throttle and current limiter: watches both channels and the register port.
// It predicts each control pass and compares results field by field. Depends on etcl_pkg.
module etcl_pass_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_bus_valid,
   input  logic [7:0]                           req_bus_throttle,
   input  logic                                 req_serial_valid,
   input  logic                                 req_pulse_valid,
   input  logic [11:0]                          req_pulse_width,
   input  logic [9:0]                           req_current_sample,
   input  logic                                 req_average_due,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [7:0]                           rsp_duty,
   input  logic [8:0]                           rsp_compare_a,
   input  logic [7:0]                           rsp_compare_b,
   input  logic                                 rsp_overcurrent,
   input  logic                                 rsp_warning_led,
   input  logic [7:0]                           rsp_mean_current,
   input  logic [7:0]                           rsp_ceiling,
   input  logic                                 csr_write_enable,
   input  logic [etcl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [etcl_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                   failure_count,
   output int                                   pending_results
);

   typedef struct packed {
      logic [7:0] duty;
      logic [8:0] compare_a;
      logic [7:0] compare_b;
      logic       overcurrent;
      logic       warning_led;
      logic [7:0] mean_current;
      logic [7:0] ceiling;
   } pass_outcome_type;

   // Shadow copy of the registers and of the controller state.
   etcl_pkg::cfg_type settings;
   logic [7:0]        setpoint;
   logic [7:0]        mean_level;
   logic [7:0]        duty_ceiling;
   logic              led_on;

   pass_outcome_type  expected_outcomes[$];
   pass_outcome_type  wanted;
   int                results_seen;

   initial begin
      failure_count   = 0;
      pending_results = 0;
      results_seen    = 0;
   end

   task automatic report_failure(input string message);
      $display("checker: transaction %0d: %s", results_seen, message);
      failure_count++;
   endtask

   task automatic compare_field(input string field, input int got, input int want);
      if (got != want) begin
         report_failure($sformatf("%s is %0d, expected %0d", field, got, want));
      end
   endtask

   // Linear map of the pulse width onto the duty range, with the out-of-range repairs.
   function automatic logic [7:0] scaled_throttle(input logic [11:0] width);
      int w;
      int mp;
      int md;
      int fd;
      int span;
      int num;
      int val;
      w  = int'(width);
      mp = int'(settings.min_pulse);
      md = int'(settings.min_duty);
      fd = int'(settings.full_duty);
      if (w > int'(etcl_pkg::PULSE_INVALID_ABOVE)) w = 0;
      if (w > int'(etcl_pkg::PULSE_CLIP)) w = int'(etcl_pkg::PULSE_CLIP);
      if (w <= mp) return 8'd0;
      // A minimum at or above the span top makes the slope infinitely steep.
      if (mp >= int'(etcl_pkg::PULSE_SPAN_TOP)) return settings.full_duty;
      span = int'(etcl_pkg::PULSE_SPAN_TOP) - mp;
      num  = (fd - md) * (w - mp);
      val  = md + num / span;
      if (val < 0 || val > fd) return settings.full_duty;
      return val[7:0];
   endfunction

   // One control pass: updates the shadow state and returns what the block should report.
   function automatic pass_outcome_type run_control_pass(input logic bus_valid,
                                                         input logic [7:0] bus_throttle,
                                                         input logic serial_valid,
                                                         input logic pulse_valid,
                                                         input logic [11:0] pulse_width,
                                                         input logic [9:0] current_sample,
                                                         input logic average_due);
      pass_outcome_type o;
      logic [7:0]       duty;
      logic [9:0]       level_sample;
      logic             over;
      if (bus_valid) begin
         setpoint = bus_throttle;
         led_on   = 1'b0;
      end else if (serial_valid) begin
         // The serial link holds the present setpoint.
      end else if (pulse_valid) begin
         setpoint = scaled_throttle(pulse_width);
         led_on   = 1'b0;
      end else begin
         if (setpoint != 8'd0) setpoint = setpoint - 8'd1;
         led_on = 1'b1;
      end
      if (setpoint > settings.full_duty) setpoint = settings.full_duty;

      duty = (settings.manual_duty != 8'd0) ? settings.manual_duty : setpoint;
      if (duty > duty_ceiling) begin
         duty   = duty_ceiling;
         led_on = 1'b1;
      end

      over         = current_sample > settings.trip_current;
      level_sample = current_sample;
      if (over) begin
         duty         = 8'd0;
         led_on       = 1'b1;
         level_sample = current_sample - 10'd1;
      end
      o.duty        = duty;
      o.compare_a   = settings.double_wide ? {duty, 1'b0} : {1'b0, duty};
      o.compare_b   = duty;
      o.overcurrent = over;

      // The mean moves one count per tick; the ceiling follows the mean.
      if (average_due) begin
         if ({2'b00, mean_level} < level_sample) begin
            if (mean_level != 8'hFF) mean_level = mean_level + 8'd1;
         end else if ({2'b00, mean_level} > level_sample) begin
            mean_level = mean_level - 8'd1;
         end
         if (mean_level > settings.average_limit) begin
            if (duty_ceiling != 8'd0) duty_ceiling = duty_ceiling - 8'd1;
            led_on = 1'b1;
         end else if (duty_ceiling < settings.full_duty) begin
            duty_ceiling = duty_ceiling + 8'd1;
         end
      end
      o.warning_led  = led_on;
      o.mean_current = mean_level;
      o.ceiling      = duty_ceiling;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings.min_pulse     = etcl_pkg::RST_MIN_PULSE;
         settings.min_duty      = etcl_pkg::RST_MIN_DUTY;
         settings.full_duty     = etcl_pkg::RST_FULL_DUTY;
         settings.trip_current  = etcl_pkg::RST_TRIP_CURRENT;
         settings.average_limit = etcl_pkg::RST_AVERAGE_LIMIT;
         settings.manual_duty   = etcl_pkg::RST_MANUAL_DUTY;
         settings.double_wide   = etcl_pkg::RST_DOUBLE_WIDE;
         setpoint     = 8'd0;
         mean_level   = 8'd0;
         duty_ceiling = etcl_pkg::RST_FULL_DUTY;
         led_on       = 1'b1;
         expected_outcomes.delete();
      end else begin
         // Register writes are to land only while the block is idle; the user is bound, not enforced here.
         if (csr_write_enable) begin
            case (csr_index)
               etcl_pkg::REG_MIN_PULSE:     settings.min_pulse     = csr_data[7:0];
               etcl_pkg::REG_MIN_DUTY:      settings.min_duty      = csr_data[7:0];
               etcl_pkg::REG_FULL_DUTY:     settings.full_duty     = csr_data[7:0];
               etcl_pkg::REG_TRIP_CURRENT:  settings.trip_current  = csr_data[9:0];
               etcl_pkg::REG_AVERAGE_LIMIT: settings.average_limit = csr_data[7:0];
               etcl_pkg::REG_MANUAL_DUTY:   settings.manual_duty   = csr_data[7:0];
               etcl_pkg::REG_DOUBLE_WIDE:   settings.double_wide   = csr_data[0];
               default: ;
            endcase
         end

         // A result leaving the block is checked before any new transaction is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_failure($sformatf("result with nothing expected, duty %0d", rsp_duty));
            end else begin
               wanted = expected_outcomes.pop_front();
               compare_field("duty", int'(rsp_duty), int'(wanted.duty));
               compare_field("compare_a", int'(rsp_compare_a), int'(wanted.compare_a));
               compare_field("compare_b", int'(rsp_compare_b), int'(wanted.compare_b));
               compare_field("overcurrent", int'(rsp_overcurrent), int'(wanted.overcurrent));
               compare_field("warning_led", int'(rsp_warning_led), int'(wanted.warning_led));
               compare_field("mean_current", int'(rsp_mean_current),
                             int'(wanted.mean_current));
               compare_field("ceiling", int'(rsp_ceiling), int'(wanted.ceiling));
            end
            results_seen++;
         end

         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(run_control_pass(req_bus_valid, req_bus_throttle,
                                                         req_serial_valid, req_pulse_valid,
                                                         req_pulse_width, req_current_sample,
                                                         req_average_due));
         end
      end
      pending_results = expected_outcomes.size();
   end

endmodule

// ----- verif/tb_esc_throttle_current_limiter_top.sv -----
// Testbench top for the throttle and current limiter: clock, reset, stimulus and verdict.
// Depends on etcl_pkg, esc_throttle_current_limiter_top and etcl_pass_checker.
module tb_esc_throttle_current_limiter_top;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COUNT     = 7;
   localparam int PHASE_ITEMS     = 80;
   localparam int SETTLE_CYCLES   = 40;

   typedef struct packed {
      logic        bus_valid;
      logic [7:0]  bus_throttle;
      logic        serial_valid;
      logic        pulse_valid;
      logic [11:0] pulse_width;
      logic [9:0]  current_sample;
      logic        average_due;
   } control_pass_type;

   logic                                clock              = 1'b0;
   logic                                reset              = 1'b1;
   logic                                req_valid          = 1'b0;
   logic                                req_stall;
   logic                                req_bus_valid      = 1'b0;
   logic [7:0]                          req_bus_throttle   = 8'd0;
   logic                                req_serial_valid   = 1'b0;
   logic                                req_pulse_valid    = 1'b0;
   logic [11:0]                         req_pulse_width    = 12'd0;
   logic [9:0]                          req_current_sample = 10'd0;
   logic                                req_average_due    = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall          = 1'b0;
   logic [7:0]                          rsp_duty;
   logic [8:0]                          rsp_compare_a;
   logic [7:0]                          rsp_compare_b;
   logic                                rsp_overcurrent;
   logic                                rsp_warning_led;
   logic [7:0]                          rsp_mean_current;
   logic [7:0]                          rsp_ceiling;
   logic                                csr_write_enable   = 1'b0;
   logic [etcl_pkg::CSR_INDEX_WIDTH-1:0] csr_index          = '0;
   logic [etcl_pkg::CSR_DATA_WIDTH-1:0]  csr_data           = '0;

   int                failure_count;
   int                pending_results;
   int                cycle_count;
   int                stall_pct       = 0;
   bit                hold_off_wanted = 1'b0;
   int                hold_count;
   etcl_pkg::cfg_type active_settings;

   esc_throttle_current_limiter_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bus_valid      (req_bus_valid),
      .req_bus_throttle   (req_bus_throttle),
      .req_serial_valid   (req_serial_valid),
      .req_pulse_valid    (req_pulse_valid),
      .req_pulse_width    (req_pulse_width),
      .req_current_sample (req_current_sample),
      .req_average_due    (req_average_due),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_duty           (rsp_duty),
      .rsp_compare_a      (rsp_compare_a),
      .rsp_compare_b      (rsp_compare_b),
      .rsp_overcurrent    (rsp_overcurrent),
      .rsp_warning_led    (rsp_warning_led),
      .rsp_mean_current   (rsp_mean_current),
      .rsp_ceiling        (rsp_ceiling),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   etcl_pass_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bus_valid      (req_bus_valid),
      .req_bus_throttle   (req_bus_throttle),
      .req_serial_valid   (req_serial_valid),
      .req_pulse_valid    (req_pulse_valid),
      .req_pulse_width    (req_pulse_width),
      .req_current_sample (req_current_sample),
      .req_average_due    (req_average_due),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_duty           (rsp_duty),
      .rsp_compare_a      (rsp_compare_a),
      .rsp_compare_b      (rsp_compare_b),
      .rsp_overcurrent    (rsp_overcurrent),
      .rsp_warning_led    (rsp_warning_led),
      .rsp_mean_current   (rsp_mean_current),
      .rsp_ceiling        (rsp_ceiling),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .failure_count      (failure_count),
      .pending_results    (pending_results)
   );

   always #6 clock = ~clock;

   // Run limit, far above the slowest correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_esc_throttle_current_limiter_top NOT OK");
      $finish;
   end

   // Receiver stalls: a random pattern whose density changes per phase, and one long hold-off.
   always begin
      @(negedge clock);
      if (hold_off_wanted) begin
         hold_off_wanted = 1'b0;
         rsp_stall <= 1'b1;
         for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) @(negedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic control_pass_type make_pass(input logic bus_valid,
                                                  input logic [7:0] bus_throttle,
                                                  input logic serial_valid,
                                                  input logic pulse_valid,
                                                  input logic [11:0] pulse_width,
                                                  input logic [9:0] current_sample,
                                                  input logic average_due);
      control_pass_type p;
      p.bus_valid      = bus_valid;
      p.bus_throttle   = bus_throttle;
      p.serial_valid   = serial_valid;
      p.pulse_valid    = pulse_valid;
      p.pulse_width    = pulse_width;
      p.current_sample = current_sample;
      p.average_due    = average_due;
      return p;
   endfunction

   // Mostly well-formed passes from one source, with noise on the lower-priority flags.
   function automatic control_pass_type random_pass(input int level);
      control_pass_type p;
      int               pick;
      int               cur;
      p.bus_throttle = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 20) p.pulse_width = 12'($urandom_range(0, 4095));
      else if (pick < 35) p.pulse_width = 12'($urandom_range(285, 315));
      else p.pulse_width = 12'($urandom_range(0, 210));

      p.bus_valid    = 1'b0;
      p.serial_valid = 1'b0;
      p.pulse_valid  = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         p.bus_valid    = 1'b1;
         p.serial_valid = 1'($urandom_range(0, 1));
         p.pulse_valid  = 1'($urandom_range(0, 1));
      end else if (pick < 40) begin
         p.serial_valid = 1'b1;
         p.pulse_valid  = 1'($urandom_range(0, 1));
      end else if (pick < 75) begin
         p.pulse_valid  = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 10) cur = $urandom_range(0, 1023);
      else if (pick < 25) cur = int'(active_settings.trip_current) + int'($urandom_range(0, 6)) - 3;
      else cur = level + int'($urandom_range(0, 30)) - 15;
      if (cur < 0) cur = 0;
      if (cur > 1023) cur = 1023;
      p.current_sample = cur[9:0];
      p.average_due    = ($urandom_range(0, 99) < 60);
      return p;
   endfunction

   function automatic etcl_pkg::cfg_type settings_for_phase(input int phase);
      etcl_pkg::cfg_type s;
      s.min_pulse     = 8'($urandom_range(0, 189));
      s.min_duty      = 8'($urandom_range(0, 255));
      s.full_duty     = 8'($urandom_range(0, 255));
      s.trip_current  = 10'($urandom_range(0, 1023));
      s.average_limit = 8'($urandom_range(0, 255));
      s.manual_duty   = 8'd0;
      s.double_wide   = 1'($urandom_range(0, 1));
      case (phase)
         0: begin
            s.min_pulse     = etcl_pkg::RST_MIN_PULSE;
            s.min_duty      = etcl_pkg::RST_MIN_DUTY;
            s.full_duty     = etcl_pkg::RST_FULL_DUTY;
            s.trip_current  = etcl_pkg::RST_TRIP_CURRENT;
            s.average_limit = etcl_pkg::RST_AVERAGE_LIMIT;
            s.double_wide   = 1'b0;
         end
         1: begin
            s.min_pulse     = 8'd0;
            s.min_duty      = 8'd0;
            s.full_duty     = 8'd255;
            s.trip_current  = 10'd1023;
            s.average_limit = 8'd0;
            s.double_wide   = 1'b1;
         end
         2: begin
            s.min_pulse     = 8'd189;
            s.min_duty      = 8'd255;
            s.full_duty     = 8'd0;
            s.trip_current  = 10'd0;
            s.average_limit = 8'd255;
            s.double_wide   = 1'b0;
         end
         3: begin
            // Minimum duty above full duty drives the scaled value out of range both ways.
            s.min_pulse     = 8'd100;
            s.min_duty      = 8'd255;
            s.full_duty     = 8'd10;
            s.trip_current  = 10'd500;
            s.average_limit = 8'd30;
            s.double_wide   = 1'b1;
         end
         4: begin
            s.min_pulse     = 8'd150;
            s.full_duty     = 8'd255;
            s.trip_current  = 10'd300;
            s.average_limit = 8'd100;
            s.manual_duty   = 8'd255;
         end
         5: ;
         default: s.manual_duty = 8'($urandom_range(1, 255));
      endcase
      return s;
   endfunction

   task automatic write_register(input logic [etcl_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [etcl_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
   endtask

   task automatic write_settings(input etcl_pkg::cfg_type s);
      write_register(etcl_pkg::REG_MIN_PULSE, {2'b00, s.min_pulse});
      write_register(etcl_pkg::REG_MIN_DUTY, {2'b00, s.min_duty});
      write_register(etcl_pkg::REG_FULL_DUTY, {2'b00, s.full_duty});
      write_register(etcl_pkg::REG_TRIP_CURRENT, s.trip_current);
      write_register(etcl_pkg::REG_AVERAGE_LIMIT, {2'b00, s.average_limit});
      write_register(etcl_pkg::REG_MANUAL_DUTY, {2'b00, s.manual_duty});
      write_register(etcl_pkg::REG_DOUBLE_WIDE, {9'd0, s.double_wide});
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_settings = s;
   endtask

   // Offer one transaction and return at the edge that accepts it.
   task automatic send_item(input control_pass_type p);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_bus_valid      <= p.bus_valid;
      req_bus_throttle   <= p.bus_throttle;
      req_serial_valid   <= p.serial_valid;
      req_pulse_valid    <= p.pulse_valid;
      req_pulse_width    <= p.pulse_width;
      req_current_sample <= p.current_sample;
      req_average_due    <= p.average_due;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_cycles(input int count);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (count - 1) @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has been seen.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      etcl_pkg::cfg_type s;
      int                phase;
      int                item;
      int                burst_left;
      int                level;
      int                stall_plan[PHASE_COUNT];

      stall_plan = '{0, 25, 60, 10, 40, 0, 80};
      active_settings.min_pulse     = etcl_pkg::RST_MIN_PULSE;
      active_settings.min_duty      = etcl_pkg::RST_MIN_DUTY;
      active_settings.full_duty     = etcl_pkg::RST_FULL_DUTY;
      active_settings.trip_current  = etcl_pkg::RST_TRIP_CURRENT;
      active_settings.average_limit = etcl_pkg::RST_AVERAGE_LIMIT;
      active_settings.manual_duty   = etcl_pkg::RST_MANUAL_DUTY;
      active_settings.double_wide   = etcl_pkg::RST_DOUBLE_WIDE;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed passes on the reset settings: each source, pulse limits, decay, overcurrent.
      send_item(make_pass(1'b1, 8'd255, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b1, 8'd0, 1'b1, 1'b1, 12'd4095, 10'd0, 1'b0));
      send_item(make_pass(1'b1, 8'd128, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b1, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd255, 1'b1, 1'b1, 12'd4095, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd4095, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd301, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd300, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd10, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd11, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd190, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd100, 10'd200, 1'b1));
      send_item(make_pass(1'b1, 8'd200, 1'b0, 1'b0, 12'd0, 10'd201, 1'b0));
      send_item(make_pass(1'b1, 8'd200, 1'b0, 1'b0, 12'd0, 10'd1023, 1'b1));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b0, 12'd0, 10'd0, 1'b1));

      // Steep pulse scale, setpoint clamp to full duty, doubled compare, ceiling cut.
      drain_results();
      s.min_pulse     = 8'd190;
      s.min_duty      = 8'd50;
      s.full_duty     = 8'd100;
      s.trip_current  = 10'd1023;
      s.average_limit = 8'd0;
      s.manual_duty   = 8'd0;
      s.double_wide   = 1'b1;
      write_settings(s);
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd191, 10'd0, 1'b0));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd190, 10'd0, 1'b0));
      send_item(make_pass(1'b1, 8'd255, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b1, 8'd255, 1'b0, 1'b0, 12'd0, 10'd1023, 1'b1));

      // Manual duty override, zero trip level and a pulse at the top of the clip.
      drain_results();
      s.min_pulse     = 8'd0;
      s.min_duty      = 8'd255;
      s.full_duty     = 8'd255;
      s.trip_current  = 10'd0;
      s.average_limit = 8'd255;
      s.manual_duty   = 8'd77;
      s.double_wide   = 1'b1;
      write_settings(s);
      send_item(make_pass(1'b1, 8'd0, 1'b0, 1'b0, 12'd0, 10'd0, 1'b0));
      send_item(make_pass(1'b1, 8'd0, 1'b0, 1'b0, 12'd0, 10'd1, 1'b1));
      send_item(make_pass(1'b0, 8'd0, 1'b0, 1'b1, 12'd200, 10'd0, 1'b0));

      // Random phases, one register setting each, sent in bursts.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         write_settings(settings_for_phase(phase));
         stall_pct  = stall_plan[phase];
         level      = $urandom_range(0, 1023);
         burst_left = 0;
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (burst_left == 0) begin
               if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
               burst_left = $urandom_range(1, 16);
            end
            if (phase == 2 && item == 20) hold_off_wanted = 1'b1;
            if (phase == 3 && item == 40) drain_results();
            if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 1023);
            send_item(random_pass(level));
            burst_left--;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failure_count == 0) begin
         $display("tb_esc_throttle_current_limiter_top OK");
      end else begin
         $display("tb_esc_throttle_current_limiter_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/etcl_pkg.sv
design/etcl_csr.sv
design/etcl_divider.sv
design/esc_throttle_current_limiter_top.sv
verif/etcl_pass_checker.sv
verif/tb_esc_throttle_current_limiter_top.sv
